### rtl/segmented_crc32c_name_hash_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segmented CRC-32C name hash
// Implication checks that are left out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_CRC32C_NAME_HASH_ASSERT_SVH
`define SEGMENTED_CRC32C_NAME_HASH_ASSERT_SVH

`ifndef SYNTH

// The consequent holds in the same cycle as the antecedent.
`define SCNH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scnh: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SCNH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scnh: next-cycle check failed");

`else

`define SCNH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCNH_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/scnh_pkg.sv
// ----------------------------------------------------------------------------
// Segmented CRC-32C name hash package
// Shared constants, queue entry type and the bytewise CRC-32C function.
// ----------------------------------------------------------------------------
package scnh_pkg;

	// Depth of the queue between the front and the back.
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	// CRC-32C, reflected form.
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
	localparam logic [31:0] HIGH_BIT = 32'h8000_0000;
	localparam logic [15:0] LOW_MARK = 16'h8000;

	// Segment delimiter bytes.
	localparam logic [7:0] DELIM_DOT   = 8'h2E;
	localparam logic [7:0] DELIM_DASH  = 8'h2D;
	localparam logic [7:0] DELIM_UNDER = 8'h5F;
	localparam logic [7:0] DELIM_TILDE = 8'h7E;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       no_byte;
		logic       delim;
		logic       ends;
	} item_t;

	// Queue status seen by the front and the top level.
	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	// One byte through the reflected CRC-32C register.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'h0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// True for the bytes that split a name into segments.
	function automatic logic is_delim(input logic [7:0] data);
		return (data == DELIM_DOT) || (data == DELIM_DASH) ||
			(data == DELIM_UNDER) || (data == DELIM_TILDE);
	endfunction

endpackage

### rtl/scnh_front.sv
// ----------------------------------------------------------------------------
// Name hash front
// Accepts name bytes and classifies them for the back.
// ----------------------------------------------------------------------------
module scnh_front (
	input  logic           push,
	output logic           full,
	input  logic [7:0]     name_byte,
	input  logic           last_byte,
	input  logic           empty_name,
	input  scnh_pkg::qstat_t q_stat,
	output logic           q_push,
	output scnh_pkg::item_t  q_item
);
	import scnh_pkg::*;

	// The input side stalls only when the queue has no room.
	assign full   = q_stat.full;
	assign q_push = push && !q_stat.full;

	// Classify the item: a byte is a delimiter or a segment byte, and an
	// item ends the name on the last byte or on the empty flag.
	always_comb begin
		q_item.data    = name_byte;
		q_item.no_byte = empty_name;
		q_item.delim   = !empty_name && is_delim(name_byte);
		q_item.ends    = empty_name || last_byte;
	end

endmodule

### rtl/scnh_queue.sv
// ----------------------------------------------------------------------------
// Name hash item queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module scnh_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  scnh_pkg::item_t  wr_item,
	input  logic             rd_en,
	output scnh_pkg::item_t  rd_item,
	output scnh_pkg::qstat_t stat
);
	import scnh_pkg::*;

	item_t             entries_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  count_q;

	// Status and head of the queue.
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == QCntW'(QDepth));
	assign rd_item    = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/scnh_back.sv
// ----------------------------------------------------------------------------
// Name hash back
// Runs the segment and whole-name CRCs, sums segments and forms the key.
// ----------------------------------------------------------------------------
module scnh_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  scnh_pkg::item_t q_item,
	output logic            q_take,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     key_high,
	output logic [31:0]     key_low
);
	import scnh_pkg::*;

	logic [31:0] seg_crc_q;
	logic        seg_open_q;
	logic [31:0] seg_sum_q;
	logic [31:0] whole_crc_q;
	logic        out_valid_q;
	logic [31:0] key_high_q;
	logic [31:0] key_low_q;

	logic [31:0] seg_crc_upd;
	logic [31:0] whole_crc_upd;
	logic [31:0] addend;
	logic [31:0] sum_new;
	logic [31:0] fold;
	logic        out_free;

	// An ending item needs a free result slot; other items go straight in.
	assign out_free = !out_valid_q || pop;
	assign q_take   = q_valid && (!q_item.ends || out_free);

	// Byte updates of both CRC registers.
	assign seg_crc_upd   = crc32c_byte(seg_crc_q, q_item.data);
	assign whole_crc_upd = q_item.no_byte ? whole_crc_q : crc32c_byte(whole_crc_q, q_item.data);

	// The segment that closes on this item, if any, goes into the sum.
	always_comb begin
		if (!q_item.no_byte && !q_item.delim) begin
			addend = q_item.ends ? (seg_crc_upd ^ CRC_SEED) : '0;
		end else begin
			addend = seg_open_q ? (seg_crc_q ^ CRC_SEED) : '0;
		end
	end
	assign sum_new = seg_sum_q + addend;
	assign fold    = whole_crc_upd ^ CRC_SEED;

	// Running name state, returned to its seed at the end of each name.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_crc_q   <= CRC_SEED;
			seg_open_q  <= 1'b0;
			seg_sum_q   <= '0;
			whole_crc_q <= CRC_SEED;
		end else if (q_take) begin
			if (q_item.ends) begin
				seg_crc_q   <= CRC_SEED;
				seg_open_q  <= 1'b0;
				seg_sum_q   <= '0;
				whole_crc_q <= CRC_SEED;
			end else begin
				whole_crc_q <= whole_crc_upd;
				seg_sum_q   <= sum_new;
				if (q_item.delim) begin
					seg_crc_q  <= CRC_SEED;
					seg_open_q <= 1'b0;
				end else begin
					seg_crc_q  <= seg_crc_upd;
					seg_open_q <= 1'b1;
				end
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_take && q_item.ends) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (q_take && q_item.ends) begin
			key_high_q <= sum_new | HIGH_BIT;
			key_low_q  <= {fold[31:16] ^ fold[15:0], LOW_MARK};
		end
	end

	assign empty    = !out_valid_q;
	assign key_high = key_high_q;
	assign key_low  = key_low_q;

endmodule

### rtl/segmented_crc32c_name_hash.sv
// Path: the final byte (or empty flag) is written into the queue when it is
// transferred in, and the back registers the key in the result register at the
// edge at which it takes the item from the queue head.
// Throughput: one name byte per cycle while the queue has room; a full result
// register stalls only ending items.
// Reset: arst_n clears the queue and result flag at once and seeds both CRCs.
// ----------------------------------------------------------------------------
// Segmented CRC-32C name hash
// Hashes a filename, one byte per transfer, into a 64-bit directory key.
// ----------------------------------------------------------------------------
`include "segmented_crc32c_name_hash_assert.svh"

module segmented_crc32c_name_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  name_byte,
	input  logic        last_byte,
	input  logic        empty_name,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] key_high,
	output logic [31:0] key_low
);
	import scnh_pkg::*;

	qstat_t q_stat;
	item_t  q_wr_item;
	item_t  q_item;
	logic   q_push;
	logic   q_take;

	// Front: takes and classifies bytes.
	scnh_front u_front (
		.push       (push),
		.full       (full),
		.name_byte  (name_byte),
		.last_byte  (last_byte),
		.empty_name (empty_name),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_item     (q_wr_item)
	);

	// Queue between the front and the back.
	scnh_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_wr_item),
		.rd_en   (q_take),
		.rd_item (q_item),
		.stat    (q_stat)
	);

	// Back: CRC state, segment sum and key register.
	scnh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_stat.valid),
		.q_item   (q_item),
		.q_take   (q_take),
		.empty    (empty),
		.pop      (pop),
		.key_high (key_high),
		.key_low  (key_low)
	);

	// An ending item always leaves a key waiting in the next cycle.
	`SCNH_ASSERT_NXT(a_end_gives_key, clk, arst_n, q_take && q_item.ends, !empty)
	// The back only takes an item that the queue holds.
	`SCNH_ASSERT_IMP(a_take_needs_item, clk, arst_n, q_take, q_stat.valid)
	// A full queue is never seen as holding nothing.
	`SCNH_ASSERT_IMP(a_full_has_item, clk, arst_n, q_stat.full, q_stat.valid)

endmodule

### tb/tb_segmented_crc32c_name_hash.sv
// ----------------------------------------------------------------------------
// Testbench for the segmented CRC-32C name hash
// Streams filename bytes into the hash, with random gaps and stalls on both
// queue sides, and checks every directory key against an in-bench model or a typed key.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segmented_crc32c_name_hash;
	import scnh_pkg::*;

	// One directory key as it leaves the block.
	typedef struct packed {
		logic [31:0] hi;
		logic [31:0] lo;
	} dir_key_t;

	// One directed transfer, with a typed key where it is obvious.
	typedef struct packed {
		logic [7:0]  b;
		logic        l;
		logic        e;
		logic        typed;
		logic [31:0] hi;
		logic [31:0] lo;
	} stim_row_t;

	localparam int NumRows     = 23;
	localparam int RandomItems = 1500;
	localparam int HoldCycles  = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  name_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        empty_name = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] key_high;
	logic [31:0] key_low;

	// Model state for the name being hashed.
	logic [31:0] seg_crc = CRC_SEED;
	logic        seg_open = 1'b0;
	logic [31:0] seg_sum = '0;
	logic [31:0] name_crc = CRC_SEED;

	dir_key_t pending_keys[$];

	int items_in = 0;
	int keys_seen = 0;
	int flag_ends = 0;
	int full_cycles = 0;
	int errors = 0;
	int shown = 0;
	int hold_left = 0;
	logic hold_req = 1'b0;
	logic no_idle = 1'b0;

	logic [7:0] split_set [4] = '{DELIM_DOT, DELIM_DASH, DELIM_UNDER, DELIM_TILDE};

	// Directed names: empty names, delimiter runs, byte extremes, early end flag.
	stim_row_t stim_rows [NumRows] = '{
		'{8'hFF, 1'b1, 1'b1, 1'b1, 32'h8000_0000, 32'h0000_8000},
		'{8'h00, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 32'h0000_8000},
		'{8'h61, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_DOT, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_DASH, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_UNDER, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_TILDE, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h78, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_DOT, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_DOT, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h79, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_UNDER, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h61, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h62, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{DELIM_TILDE, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h80, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h7F, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h61, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'h62, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{8'hA5, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0},
		'{8'h5A, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 32'h0000_8000}
	};

	segmented_crc32c_name_hash u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.name_byte  (name_byte),
		.last_byte  (last_byte),
		.empty_name (empty_name),
		.empty      (empty),
		.pop        (pop),
		.key_high   (key_high),
		.key_low    (key_low)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Reflected CRC-32C register advanced by one byte.
	function automatic logic [31:0] crc32c_next(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c ^ {24'h0, d};
		repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		return r;
	endfunction

	// Adds the open segment's CRC into the running sum and starts a new one.
	task automatic fold_segment();
		if (seg_open)
			seg_sum = seg_sum + (seg_crc ^ CRC_SEED);
		seg_crc = CRC_SEED;
		seg_open = 1'b0;
	endtask

	// Advances the model by one transfer and yields the key when a name ends.
	task automatic hash_predict(input logic [7:0] b, input logic l, input logic e,
			output logic done, output dir_key_t k);
		logic [31:0] f;
		k = '0;
		if (!e) begin
			name_crc = crc32c_next(name_crc, b);
			if (b == DELIM_DOT || b == DELIM_DASH || b == DELIM_UNDER || b == DELIM_TILDE) begin
				fold_segment();
			end else begin
				seg_crc = crc32c_next(seg_crc, b);
				seg_open = 1'b1;
			end
		end
		done = e || l;
		if (done) begin
			fold_segment();
			f = name_crc ^ CRC_SEED;
			f = f ^ (f << 16);
			k.hi = seg_sum | HIGH_BIT;
			k.lo = {f[31:16], LOW_MARK};
			seg_sum = '0;
			name_crc = CRC_SEED;
		end
	endtask

	// Offers one item, waits for its transfer and records any key it causes.
	task automatic send_item(input logic [7:0] b, input logic l, input logic e,
			input logic typed, input dir_key_t typed_key);
		logic done;
		dir_key_t k;
		push <= 1'b1;
		name_byte <= b;
		last_byte <= l;
		empty_name <= e;
		@(posedge clk);
		while (full) begin
			full_cycles++;
			@(posedge clk);
		end
		items_in++;
		hash_predict(b, l, e, done, k);
		if (done) begin
			pending_keys.push_back(typed ? typed_key : k);
			if (e)
				flag_ends++;
		end
	endtask

	// Random gap on the input side, suppressed during the busy stretches.
	task automatic rest_a_while();
		if (!no_idle && !hold_req && hold_left == 0 && $urandom_range(99) < 33) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	// Mostly letters and delimiters, with some bytes from the whole range.
	function automatic logic [7:0] pick_byte();
		int r;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 25)
			b = split_set[$urandom_range(3)];
		else if (r < 70)
			b = 8'h61 + 8'($urandom_range(25));
		else
			b = 8'($urandom_range(255));
		return b;
	endfunction

	// One random name, or with noisy set, a run of loosely formed transfers.
	task automatic offer_name(input int max_len, input logic noisy);
		int len;
		int ending;
		len = $urandom_range(1, max_len);
		ending = $urandom_range(99);
		if (noisy) begin
			for (int k = 0; k < len; k++) begin
				send_item(pick_byte(), $urandom_range(99) < 30, $urandom_range(99) < 10,
					1'b0, '0);
				rest_a_while();
			end
		end else if (ending < 5) begin
			send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0, '0);
			rest_a_while();
		end else begin
			for (int k = 0; k < len; k++) begin
				send_item(pick_byte(), (k == len - 1) && ending >= 15, 1'b0, 1'b0, '0);
				rest_a_while();
			end
			if (ending < 15) begin
				send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0, '0);
				rest_a_while();
			end
		end
	endtask

	// Compares one transferred key with the oldest expected one.
	task automatic take_key();
		dir_key_t want;
		keys_seen++;
		if (pending_keys.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("ERROR: key %h_%h with none expected", key_high, key_low);
			end
		end else begin
			want = pending_keys.pop_front();
			if (key_high !== want.hi || key_low !== want.lo) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("ERROR: key %0d: expected %h_%h, got %h_%h", keys_seen,
						want.hi, want.lo, key_high, key_low);
				end
			end
		end
	endtask

	// Result side: checks each transfer, idles at random, and holds off on request.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				take_key();
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (no_idle) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= 33);
			end
		end
	end

	// Input side: reset, directed rows, then random names with pressure phases.
	initial begin
		int waited;
		logic paused;
		logic held;
		paused = 1'b0;
		held = 1'b0;
		waited = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NumRows; i++) begin
			send_item(stim_rows[i].b, stim_rows[i].l, stim_rows[i].e, stim_rows[i].typed,
				'{hi: stim_rows[i].hi, lo: stim_rows[i].lo});
			rest_a_while();
		end

		while (items_in < NumRows + RandomItems) begin
			// Input pause until every key in flight has been transferred out.
			if (!paused && items_in >= 400) begin
				paused = 1'b1;
				push <= 1'b0;
				@(posedge clk);
				while (pending_keys.size() != 0) @(posedge clk);
			end
			// Long hold on the result side while short names keep coming.
			if (!held && items_in >= 700) begin
				held = 1'b1;
				hold_req = 1'b1;
				while (hold_req || hold_left != 0) offer_name(2, 1'b0);
			end
			no_idle = (items_in >= 1000 && items_in < 1300);
			if ($urandom_range(99) < 10)
				offer_name(6, 1'b1);
			else if ($urandom_range(99) < 90)
				offer_name(8, 1'b0);
			else
				offer_name(40, 1'b0);
		end
		no_idle = 1'b0;
		push <= 1'b0;

		// Drain the keys still in flight, then allow for the block's latency.
		while (pending_keys.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_keys.size() != 0) begin
			errors += pending_keys.size();
			$display("ERROR: %0d keys never arrived", pending_keys.size());
		end

		$display("Run: %0d bytes and flags in, %0d keys out, %0d names ended by the empty flag.",
			items_in, keys_seen, flag_ends);
		$display("Run: input held back by a full queue for %0d cycles, %0d mismatches.",
			full_cycles, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
